[src/fkst_pkg.sv]
// ----------------------------------------------------------------------------
// fkst_pkg
// Shared types and constants of the keyed slot table.
// ----------------------------------------------------------------------------
package fkst_pkg;

   localparam logic [31:0] SEED_RESET  = 32'd2166136261;
   localparam logic [31:0] PRIME_RESET = 32'd16777619;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIME = 2'd1;

   localparam logic [2:0] CMD_ADD      = 3'd0;
   localparam logic [2:0] CMD_REMOVE   = 3'd1;
   localparam logic [2:0] CMD_GET_KEY  = 3'd2;
   localparam logic [2:0] CMD_GET_HASH = 3'd3;
   localparam logic [2:0] CMD_CLEAR    = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD,
      OP_REMOVE,
      OP_GET,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] hash;
      logic [31:0] value;
   } job_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_CLEAR
   } state_type;

endpackage

[src/fkst_front.sv]
// ----------------------------------------------------------------------------
// fkst_front
// Accepts key bytes, folds them by FNV-1a and classifies the finished command.
// ----------------------------------------------------------------------------
module fkst_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [2:0]                          req_command,
   input  logic [7:0]                          req_key_byte,
   input  logic                                req_key_last,
   input  logic [31:0]                         req_hash_given,
   input  logic [31:0]                         req_value_in,
   input  logic                                csr_we,
   input  logic [fkst_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_data,
   output logic                                push,
   output fkst_pkg::job_type                   push_job
);
   import fkst_pkg::*;

   logic [31:0] seed_ff, seed_in;
   logic [31:0] prime_ff, prime_in;
   logic [31:0] run_ff, run_in;
   logic        key_open_ff, key_open_in;
   logic        key_ended_ff, key_ended_in;

   logic        accept;
   logic        skip;
   logic [31:0] base;
   logic [31:0] mix;
   logic [31:0] fold;
   logic [31:0] h_next;

   assign accept = start && !busy;
   assign base   = key_open_ff ? run_ff : seed_ff;
   assign skip   = (key_open_ff && key_ended_ff) || (req_key_byte == 8'd0);
   assign mix    = base ^ {24'd0, req_key_byte};
   assign fold   = mix * prime_ff;
   assign h_next = skip ? base : fold;

   always_comb begin
      seed_in  = seed_ff;
      prime_in = prime_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SEED:  seed_in  = csr_data;
            CSR_PRIME: prime_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      run_in       = run_ff;
      key_open_in  = key_open_ff;
      key_ended_in = key_ended_ff;
      if (accept) begin
         run_in = h_next;
         if (req_key_last) begin
            key_open_in  = 1'b0;
            key_ended_in = 1'b0;
         end else begin
            key_open_in  = 1'b1;
            key_ended_in = skip;
         end
      end
   end

   always_comb begin
      push           = accept && req_key_last;
      push_job.op    = OP_NONE;
      push_job.hash  = h_next;
      push_job.value = req_value_in;
      case (req_command)
         CMD_ADD:     push_job.op = (h_next != 32'd0) ? OP_ADD : OP_NONE;
         CMD_REMOVE:  push_job.op = (h_next != 32'd0) ? OP_REMOVE : OP_NONE;
         CMD_GET_KEY: push_job.op = (h_next != 32'd0) ? OP_GET : OP_NONE;
         CMD_GET_HASH: begin
            push_job.hash = req_hash_given;
            push_job.op   = (req_hash_given != 32'd0) ? OP_GET : OP_NONE;
         end
         CMD_CLEAR:   push_job.op = OP_CLEAR;
         default:     push_job.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_RESET;
         prime_ff     <= PRIME_RESET;
         key_open_ff  <= 1'b0;
         key_ended_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         prime_ff     <= prime_in;
         key_open_ff  <= key_open_in;
         key_ended_ff <= key_ended_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

endmodule

[src/fkst_queue.sv]
// ----------------------------------------------------------------------------
// fkst_queue
// Short job queue between the hashing front and the table back end.
// ----------------------------------------------------------------------------
module fkst_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fkst_pkg::job_type push_job,
   input  logic              pop,
   output fkst_pkg::job_type head,
   output logic              empty,
   output logic              full
);
   import fkst_pkg::*;

   job_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[src/fkst_back.sv]
// ----------------------------------------------------------------------------
// fkst_back
// Slot memory and the sequencer that scans, writes and clears it.
// ----------------------------------------------------------------------------
module fkst_back #(
   parameter int TABLE_SLOTS = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  fkst_pkg::job_type head,
   input  logic              empty,
   output logic              pop,
   output logic              init_busy,
   output logic              rsp_valid,
   output logic              rsp_success,
   output logic [31:0]       rsp_hash_out,
   output logic [31:0]       rsp_value_out
);
   import fkst_pkg::*;

   localparam int AW      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW      = $clog2(TABLE_SLOTS + 1);
   localparam int STORE_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam int ENTRY_W = 32 + STORE_W;

   logic [ENTRY_W-1:0] slot_mem [TABLE_SLOTS];

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               q_valid_ff, q_valid_in;
   logic [ENTRY_W-1:0] rd_q_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_success_ff, rsp_success_in;
   logic [31:0]        rsp_hash_ff, rsp_hash_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_re;

   logic [31:0]        rd_hash;
   logic [STORE_W-1:0] rd_value;
   logic [31:0]        target;
   logic               hit;
   logic               miss;
   logic               last_ptr;
   logic               scan_end;

   assign rd_hash  = rd_q_ff[ENTRY_W-1 -: 32];
   assign rd_value = rd_q_ff[STORE_W-1:0];
   assign target   = (job_ff.op == OP_ADD) ? 32'd0 : job_ff.hash;
   assign hit      = q_valid_ff && (rd_hash == target);
   assign scan_end = (ptr_ff == CW'(TABLE_SLOTS));
   assign miss     = q_valid_ff && !hit && scan_end;
   assign last_ptr = (ptr_ff == CW'(TABLE_SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (last_ptr) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!empty) begin
               case (head.op)
                  OP_ADD, OP_REMOVE, OP_GET: state_in = ST_SCAN;
                  OP_CLEAR:                  state_in = ST_CLEAR;
                  default:                   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit || miss) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (last_ptr) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop            = 1'b0;
      job_in         = job_ff;
      ptr_in         = ptr_ff;
      idx_in         = idx_ff;
      q_valid_in     = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = ptr_ff[AW-1:0];
      mem_wdata      = '0;
      mem_re         = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_success_in = 1'b0;
      rsp_hash_in    = 32'd0;
      rsp_value_in   = 32'd0;
      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            ptr_in = last_ptr ? '0 : ptr_ff + CW'(1);
         end
         ST_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               job_in = head;
               ptr_in = '0;
               if (head.op == OP_NONE) rsp_valid_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = 1'b1;
               mem_waddr      = idx_ff;
               case (job_ff.op)
                  OP_ADD: begin
                     mem_we      = 1'b1;
                     mem_wdata   = {job_ff.hash, job_ff.value[STORE_W-1:0]};
                     rsp_hash_in = job_ff.hash;
                  end
                  OP_REMOVE: mem_we = 1'b1;
                  OP_GET:    rsp_value_in = 32'(rd_value);
                  default: ;
               endcase
            end else if (miss) begin
               rsp_valid_in = 1'b1;
            end else if (!scan_end) begin
               mem_re     = 1'b1;
               idx_in     = ptr_ff[AW-1:0];
               q_valid_in = 1'b1;
               ptr_in     = ptr_ff + CW'(1);
            end
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = last_ptr ? '0 : ptr_ff + CW'(1);
            if (last_ptr) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_q_ff <= slot_mem[ptr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         q_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         q_valid_ff   <= q_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      idx_ff         <= idx_in;
      rsp_success_ff <= rsp_success_in;
      rsp_hash_ff    <= rsp_hash_in;
      rsp_value_ff   <= rsp_value_in;
   end

   assign init_busy     = (state_ff == ST_INIT);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_success   = rsp_success_ff;
   assign rsp_hash_out  = rsp_hash_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule

[src/fnv1a_keyed_slot_table.sv]
// ----------------------------------------------------------------------------
// fnv1a_keyed_slot_table
// Slot table keyed by FNV-1a hashes of streamed key bytes.
// ----------------------------------------------------------------------------
// Key bytes enter on the req_ ports, one per cycle, while busy is low; a byte
// is taken at each edge with start high and busy low. The byte marked
// req_key_last carries the command, which is queued (two deep) for the table
// sequencer. Registers hash_seed (index 0) and hash_prime (index 1) are
// written on the csr_ channel, which is always ready.
// Each command gives one result on the rsp_ ports, valid for a single cycle
// with rsp_valid high; the receiver cannot stall it.
// A command rejected up front (zero hash, unknown code) is answered when the
// sequencer takes it from the queue; add/remove/get answer when the scan hits
// the matching slot or ends, clear at the end of its pass. The slot scan
// reads one slot per cycle from a single-port memory; that sets the rate.
// Bytes keep flowing while the queue has room.
// After reset the slot memory is cleared in a pass over all TABLE_SLOTS slots,
// with busy high; configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
module fnv1a_keyed_slot_table #(
   parameter int TABLE_SLOTS = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [2:0]                       req_command,
   input  logic [7:0]                       req_key_byte,
   input  logic                             req_key_last,
   input  logic [31:0]                      req_hash_given,
   input  logic [31:0]                      req_value_in,
   output logic                             rsp_valid,
   output logic                             rsp_success,
   output logic [31:0]                      rsp_hash_out,
   output logic [31:0]                      rsp_value_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fkst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_data
);
   import fkst_pkg::*;

   logic    q_push;
   job_type q_push_job;
   logic    q_pop;
   job_type q_head;
   logic    q_empty;
   logic    q_full;
   logic    init_busy;

   assign csr_ready = 1'b1;
   assign busy      = init_busy || q_full;

   fkst_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_key_byte   (req_key_byte),
      .req_key_last   (req_key_last),
      .req_hash_given (req_hash_given),
      .req_value_in   (req_value_in),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .push           (q_push),
      .push_job       (q_push_job)
   );

   fkst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   fkst_back #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .empty         (q_empty),
      .pop           (q_pop),
      .init_busy     (init_busy),
      .rsp_valid     (rsp_valid),
      .rsp_success   (rsp_success),
      .rsp_hash_out  (rsp_hash_out),
      .rsp_value_out (rsp_value_out)
   );

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> rsp_hash_out == 32'd0 && rsp_value_out == 32'd0)
      else $error("failed result carries nonzero fields");

   a_add_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hash_out != 32'd0 |-> rsp_success && rsp_value_out == 32'd0)
      else $error("add result carries a value");

   a_init_busy: assert property (@(posedge clock)
      reset |=> busy)
      else $error("items accepted during the clearing pass");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

endmodule
